// ===== rtl/core/irc_tok_pkg.sv =====
// Shared types, codes and byte helpers for the IRC line tokenizer.
`default_nettype none

package irc_tok_pkg;

    // Parse phase of the line.
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_PREFIX     = 3'd1,
        PH_PREFIX_GAP = 3'd2,
        PH_COMMAND    = 3'd3,
        PH_GAP        = 3'd4,
        PH_PARAM      = 3'd5,
        PH_TRAILING   = 3'd6
    } t_phase;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_RELEASE = 3'd1,
        ST_FEED    = 3'd2,
        ST_MARK    = 3'd3,
        ST_FLUSH   = 3'd4
    } t_ctl_state;

    // Field kinds.
    localparam logic [2:0] KIND_PREFIX   = 3'd0;
    localparam logic [2:0] KIND_COMMAND  = 3'd1;
    localparam logic [2:0] KIND_PARAM    = 3'd2;
    localparam logic [2:0] KIND_TRAILING = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;

    // End marker status codes.
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_EMPTY    = 3'd1;
    localparam logic [2:0] STAT_NO_CMD   = 3'd2;
    localparam logic [2:0] STAT_HOLD_OVF = 3'd3;
    localparam logic [2:0] STAT_PARAMS   = 3'd4;

    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_COLON = 8'h3A;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] field_kind;
        logic [5:0] param_index;
        logic       token_start;
        logic [2:0] status;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // capture the input word
        logic feed_held;  // run one held byte through the parser
        logic feed_byte;  // run the captured byte through the parser
        logic mark;       // emit the end marker and restart the line
        logic flush;      // move the staged result out as the last one
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_ws;      // input byte is a trim character
        logic in_eol;     // input word ends the line
        logic held_any;   // hold store is not empty
        logic held_last;  // the held byte being read is the final one
        logic cap_eol;    // captured word ends the line
        logic step_ok;    // a parser step may place a new result
        logic stg_valid;  // a result waits in the stage register
        logic out_free;   // the output register can take a result
    } t_dp_sts;

    function automatic logic is_trim_ws(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) ||
               (b == 8'h0D) || (b == 8'h0B) || (b == 8'h0C);
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) ? (b - 8'h20) : b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/irc_tok_ctrl.sv =====
// Sequencing controller of the IRC line tokenizer.
`default_nettype none

module irc_tok_ctrl
    import irc_tok_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_sts.in_ws) begin
                        n_state = i_sts.in_eol ? ST_MARK : ST_IDLE;
                    end else begin
                        n_state = i_sts.held_any ? ST_RELEASE : ST_FEED;
                    end
                end
            end
            ST_RELEASE: begin
                if (i_sts.step_ok && i_sts.held_last) begin
                    n_state = ST_FEED;
                end
            end
            ST_FEED: begin
                if (i_sts.step_ok) begin
                    n_state = i_sts.cap_eol ? ST_MARK : ST_FLUSH;
                end
            end
            ST_MARK: begin
                if (i_sts.step_ok) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!i_sts.stg_valid || i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            ST_RELEASE: begin
                o_cmd.feed_held = i_sts.step_ok;
            end
            ST_FEED: begin
                o_cmd.feed_byte = i_sts.step_ok;
            end
            ST_MARK: begin
                o_cmd.mark = i_sts.step_ok;
            end
            ST_FLUSH: begin
                o_cmd.flush = i_sts.stg_valid && i_sts.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/irc_tok_dp.sv =====
// Datapath of the IRC line tokenizer: parser state, hold memory and result registers.
`default_nettype none

module irc_tok_dp
    import irc_tok_pkg::*;
#(
    parameter int HOLD_DEPTH  = 16,
    parameter int PARAM_LIMIT = 63
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_line,
    input  wire logic       i_stall,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_sts         o_sts,
    output logic            o_valid,
    output t_result         o_result,
    output logic            o_last_result
);

    localparam int HCW = $clog2(HOLD_DEPTH + 1);
    localparam int AW  = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int PCW = $clog2(PARAM_LIMIT + 1);
    localparam logic [HCW-1:0] HoldFull = HCW'(HOLD_DEPTH);
    localparam logic [PCW-1:0] ParamMax = PCW'(PARAM_LIMIT);

    // Parser state.
    t_phase         r_phase;
    logic [HCW-1:0] r_held_count;
    logic [PCW-1:0] r_param_count;
    logic [1:0]     r_ovf;
    logic           r_fresh;

    // Captured word and hold memory read port.
    logic [7:0]     r_byte;
    logic           r_eol;
    logic [AW-1:0]  r_rd_idx;
    logic [7:0]     r_rd_data;
    logic [7:0]     r_hold [HOLD_DEPTH];

    // Stage and output registers.
    t_result        r_stg;
    logic           r_stg_valid;
    t_result        r_out;
    logic           r_out_valid;
    logic           r_out_last;

    logic           in_ws;
    logic           push_ws;
    logic           hold_wr;
    logic           held_last;
    logic [AW-1:0]  rd_addr;
    logic           out_take;
    logic           out_free;
    logic           step;
    logic           emit;
    logic           to_out;
    t_result        new_res;

    // One parser step.
    logic [7:0]     feed_b;
    logic           f_emit;
    t_result        f_res;
    t_phase         f_phase;
    logic           f_fresh;
    logic [PCW-1:0] f_pc;
    logic           f_ovf2;
    t_result        mark_res;

    assign in_ws     = is_trim_ws(i_in_byte);
    assign push_ws   = i_cmd.accept && in_ws && (r_phase != PH_IDLE);
    assign hold_wr   = push_ws && (r_held_count < HoldFull);
    assign held_last = ((HCW'(r_rd_idx) + HCW'(1)) == r_held_count);

    assign out_take = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;

    assign o_sts.in_ws     = in_ws;
    assign o_sts.in_eol    = i_end_of_line;
    assign o_sts.held_any  = (r_held_count != '0);
    assign o_sts.held_last = held_last;
    assign o_sts.cap_eol   = r_eol;
    assign o_sts.step_ok   = !r_stg_valid || out_free;
    assign o_sts.stg_valid = r_stg_valid;
    assign o_sts.out_free  = out_free;

    assign feed_b = i_cmd.feed_held ? r_rd_data : r_byte;
    assign step   = i_cmd.feed_held || i_cmd.feed_byte;

    always_comb begin
        f_emit  = 1'b0;
        f_res   = '0;
        f_phase = r_phase;
        f_fresh = r_fresh;
        f_pc    = r_param_count;
        f_ovf2  = 1'b0;
        f_res.out_byte   = feed_b;
        f_res.byte_valid = 1'b1;
        case (r_phase)
            PH_IDLE: begin
                if (feed_b == CHR_COLON) begin
                    f_phase = PH_PREFIX;
                    f_fresh = 1'b1;
                end else begin
                    f_phase           = PH_COMMAND;
                    f_emit            = 1'b1;
                    f_res.out_byte    = upcase(feed_b);
                    f_res.field_kind  = KIND_COMMAND;
                    f_res.token_start = 1'b1;
                end
            end
            PH_PREFIX: begin
                if (feed_b == CHR_SPACE) begin
                    f_phase = PH_PREFIX_GAP;
                end else begin
                    f_emit            = 1'b1;
                    f_res.field_kind  = KIND_PREFIX;
                    f_res.token_start = r_fresh;
                    f_fresh           = 1'b0;
                end
            end
            PH_PREFIX_GAP: begin
                if (feed_b != CHR_SPACE) begin
                    f_phase           = PH_COMMAND;
                    f_emit            = 1'b1;
                    f_res.out_byte    = upcase(feed_b);
                    f_res.field_kind  = KIND_COMMAND;
                    f_res.token_start = 1'b1;
                end
            end
            PH_COMMAND: begin
                if (feed_b == CHR_SPACE) begin
                    f_phase = PH_GAP;
                end else begin
                    f_emit           = 1'b1;
                    f_res.out_byte   = upcase(feed_b);
                    f_res.field_kind = KIND_COMMAND;
                end
            end
            PH_GAP: begin
                if (feed_b == CHR_COLON) begin
                    f_phase = PH_TRAILING;
                    f_fresh = 1'b1;
                end else if (feed_b != CHR_SPACE) begin
                    f_ovf2            = (r_param_count >= ParamMax);
                    f_phase           = PH_PARAM;
                    f_emit            = 1'b1;
                    f_res.field_kind  = KIND_PARAM;
                    f_res.param_index = 6'(r_param_count);
                    f_res.token_start = 1'b1;
                end
            end
            PH_PARAM: begin
                if (feed_b == CHR_SPACE) begin
                    if (r_param_count < ParamMax) begin
                        f_pc = r_param_count + PCW'(1);
                    end
                    f_phase = PH_GAP;
                end else begin
                    f_emit            = 1'b1;
                    f_res.field_kind  = KIND_PARAM;
                    f_res.param_index = 6'(r_param_count);
                end
            end
            PH_TRAILING: begin
                f_emit            = 1'b1;
                f_res.field_kind  = KIND_TRAILING;
                f_res.token_start = r_fresh;
                f_fresh           = 1'b0;
            end
            default: begin
                f_emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        mark_res             = '0;
        mark_res.field_kind  = KIND_END;
        mark_res.token_start = 1'b1;
        if (r_phase == PH_IDLE) begin
            mark_res.status = STAT_EMPTY;
        end else if ((r_phase == PH_PREFIX) || (r_phase == PH_PREFIX_GAP)) begin
            mark_res.status = STAT_NO_CMD;
        end else if (r_ovf[0]) begin
            mark_res.status = STAT_HOLD_OVF;
        end else if (r_ovf[1]) begin
            mark_res.status = STAT_PARAMS;
        end else begin
            mark_res.status = STAT_OK;
        end
    end

    assign emit    = (step && f_emit) || i_cmd.mark;
    assign new_res = i_cmd.mark ? mark_res : f_res;
    assign to_out  = (emit && r_stg_valid) || i_cmd.flush;

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_held_count  <= '0;
            r_param_count <= '0;
            r_ovf         <= '0;
            r_fresh       <= 1'b0;
        end else if (i_cmd.mark) begin
            r_phase       <= PH_IDLE;
            r_held_count  <= '0;
            r_param_count <= '0;
            r_ovf         <= '0;
            r_fresh       <= 1'b0;
        end else if (step) begin
            r_phase       <= f_phase;
            r_fresh       <= f_fresh;
            r_param_count <= f_pc;
            r_ovf[1]      <= r_ovf[1] || f_ovf2;
            if (i_cmd.feed_byte) begin
                r_held_count <= '0;
            end
        end else if (push_ws) begin
            if (hold_wr) begin
                r_held_count <= r_held_count + HCW'(1);
            end else begin
                r_ovf[0] <= 1'b1;
            end
        end
    end

    // Captured word and read index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte   <= i_in_byte;
            r_eol    <= i_end_of_line;
            r_rd_idx <= '0;
        end else if (i_cmd.feed_held) begin
            r_rd_idx <= r_rd_idx + AW'(1);
        end
    end

    // The read address runs one entry ahead so the next held byte is ready.
    always_comb begin
        if (i_cmd.accept) begin
            rd_addr = '0;
        end else if (i_cmd.feed_held && !held_last) begin
            rd_addr = r_rd_idx + AW'(1);
        end else begin
            rd_addr = r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold_wr) begin
            r_hold[r_held_count[AW-1:0]] <= i_in_byte;
        end
        r_rd_data <= r_hold[rd_addr];
    end

    // Stage and output valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (to_out) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            if (emit) begin
                r_stg_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_stg_valid <= 1'b0;
            end
        end
    end

    // A result is held back one step until it is known whether another follows.
    always_ff @(posedge i_clk) begin
        if (to_out) begin
            r_out      <= r_stg;
            r_out_last <= i_cmd.flush;
        end
        if (emit) begin
            r_stg <= new_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result      = r_out;
    assign o_last_result = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/irc_line_tokenizer_top.sv =====
// Top level of the IRC line tokenizer.
`default_nettype none

// Streams one IRC line a byte per word and tags the emitted bytes as prefix,
// command, parameter or trailing text, with an end marker that carries the line
// status. A whitespace word that does not end the line is stored in the hold
// memory, or dropped before the line has started or when the hold memory is
// full, and yields nothing; a whitespace word that ends the line passes through
// the end marker state and then the final move to the output register. Any
// other word first has the single parser unit walk the held whitespace bytes
// one entry per cycle while the stage and output registers can take a result,
// then parse the word itself; such a word that ends the line then emits the end
// marker. Each word's final result leaves through the output register once that
// word is done, so a busy downstream stall delays it.

module irc_line_tokenizer_top
    import irc_tok_pkg::*;
#(
    parameter int HOLD_DEPTH  = 16,
    parameter int PARAM_LIMIT = 63
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_line,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic [2:0]      o_field_kind,
    output logic [5:0]      o_param_index,
    output logic            o_token_start,
    output logic [2:0]      o_status,
    output logic            o_last_result
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_result result;

    irc_tok_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    irc_tok_dp #(
        .HOLD_DEPTH  (HOLD_DEPTH),
        .PARAM_LIMIT (PARAM_LIMIT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_byte     (i_in_byte),
        .i_end_of_line (i_end_of_line),
        .i_stall       (i_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_result      (result),
        .o_last_result (o_last_result)
    );

    assign o_out_byte    = result.out_byte;
    assign o_byte_valid  = result.byte_valid;
    assign o_field_kind  = result.field_kind;
    assign o_param_index = result.param_index;
    assign o_token_start = result.token_start;
    assign o_status      = result.status;

endmodule

`default_nettype wire
